// ===== hdl/ipc_pkg.sv =====
// ----------------------------------------------------------------------------
// ipc_pkg: shared types and constants of the rendezvous engine
// Request codes, status codes, item structs, controller/datapath link types.
// ----------------------------------------------------------------------------
`default_nettype none
package ipc_pkg;
  localparam int NUM_PROCS_DEF    = 16;
  localparam int PAYLOAD_BITS_DEF = 32;

  localparam logic [1:0] REQ_SEND = 2'd0;
  localparam logic [1:0] REQ_RECV = 2'd1;
  localparam logic [1:0] REQ_INT  = 2'd2;

  localparam logic [1:0] KIND_PID = 2'd0;
  localparam logic [1:0] KIND_ANY = 2'd1;
  localparam logic [1:0] KIND_INT = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BLOCKED  = 2'd1;
  localparam logic [1:0] ST_DEADLOCK = 2'd2;
  localparam logic [1:0] ST_BAD      = 2'd3;

  localparam logic [1:0] MODE_RUN  = 2'd0;
  localparam logic [1:0] MODE_SEND = 2'd1;
  localparam logic [1:0] MODE_RECV = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  caller_pid;
    logic [1:0]  target_kind;
    logic [3:0]  target_pid;
    logic [31:0] payload;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        delivered;
    logic [3:0]  receiver_pid;
    logic [3:0]  source_pid;
    logic        from_interrupt;
    logic [31:0] msg_word;
    logic        unblocked_valid;
    logic [3:0]  unblocked_pid;
  } out_item_t;

  // controller -> datapath
  typedef enum logic [3:0] {
    CMD_NONE  = 4'd0,
    CMD_LOAD  = 4'd1,  // capture item, decode
    CMD_CHAIN = 4'd2,  // one step of the deadlock chain walk
    CMD_EXEC  = 4'd3,  // apply decision, start queue walk if needed
    CMD_WALK  = 4'd4,  // one step of the queue tail / predecessor walk
    CMD_DONE  = 4'd5   // result out register consumed
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic chain_done;
    logic walk_done;
  } dp_status_t;
endpackage
`default_nettype wire

// ===== hdl/ipc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ipc_ctrl: sequencer of the rendezvous engine
// Steps load, chain walk, execute, queue walk and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
module ipc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  input  wire ipc_pkg::dp_status_t dp_st,
  output ipc_pkg::cmd_t           cmd
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHAIN = 6'b000010,
    S_EXEC  = 6'b000100,
    S_WALK  = 6'b001000,
    S_OUT   = 6'b010000,
    S_LOAD  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = ipc_pkg::CMD_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd = ipc_pkg::CMD_LOAD;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: state_nxt = S_CHAIN;
      S_CHAIN: begin
        cmd = ipc_pkg::CMD_CHAIN;
        if (dp_st.chain_done) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd = ipc_pkg::CMD_EXEC;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        cmd = ipc_pkg::CMD_WALK;
        if (dp_st.walk_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          cmd = ipc_pkg::CMD_DONE;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end
endmodule
`default_nettype wire

// ===== hdl/ipc_dpath.sv =====
// ----------------------------------------------------------------------------
// ipc_dpath: process tables and walk logic of the rendezvous engine
// Per-process state in flops; payload store as a memory; one walk step a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module ipc_dpath #(
  parameter int NUM_PROCS    = ipc_pkg::NUM_PROCS_DEF,
  parameter int PAYLOAD_BITS = ipc_pkg::PAYLOAD_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ipc_pkg::cmd_t       cmd,
  input  wire ipc_pkg::in_item_t   in_data,
  output ipc_pkg::dp_status_t      dp_st,
  output ipc_pkg::out_item_t       out_data
);
  localparam int PW = $clog2(NUM_PROCS);
  localparam int LW = PW + 1;                // link: 0 none, else pid+1
  localparam int CW = $clog2(NUM_PROCS + 1); // step counter
  localparam logic [5:0] SRC_ANY = 6'd62;
  localparam logic [5:0] SRC_INT = 6'd63;

  logic [1:0]    mode_r   [NUM_PROCS];
  logic [PW-1:0] stgt_r   [NUM_PROCS];
  logic [5:0]    wsrc_r   [NUM_PROCS];
  logic          pend_r   [NUM_PROCS];
  logic [LW-1:0] qhead_r  [NUM_PROCS];
  logic [LW-1:0] qnext_r  [NUM_PROCS];
  logic [PAYLOAD_BITS-1:0] held_mem [NUM_PROCS];

  ipc_pkg::in_item_t req_r;
  logic [PAYLOAD_BITS-1:0] word_r, held_rd_r;
  logic          pid_ok_c, pid_ok_t, caller_run;
  logic [PW-1:0] cp, tp;
  logic [PW-1:0] wp_r;        // chain walk pointer
  logic [CW-1:0] cnt_r;
  logic          chain_done_r, dead_r;
  logic          walk_act_r, walk_unlink_r; // 0: tail walk (enqueue), unlink else
  logic [PW-1:0] wsub_r;      // sender being queued / removed
  logic [PW-1:0] owner_r;
  logic [LW-1:0] link_r, prev_r;
  ipc_pkg::out_item_t res_r;
  logic          read_held_r;
  logic [PW-1:0] from_pid_r;

  assign cp = req_r.caller_pid[PW-1:0];
  assign tp = req_r.target_pid[PW-1:0];
  assign pid_ok_c = ({28'd0, req_r.caller_pid} < 32'(NUM_PROCS));
  assign pid_ok_t = ({28'd0, req_r.target_pid} < 32'(NUM_PROCS));
  assign caller_run = pid_ok_c && (mode_r[cp] == ipc_pkg::MODE_RUN);

  assign dp_st.chain_done = chain_done_r;
  assign dp_st.walk_done  = !walk_act_r;

  // held payload read is registered; merged into the result during the walk
  always_comb begin
    out_data = res_r;
    if (read_held_r) out_data.msg_word = 32'(held_rd_r);
  end

  logic [LW-1:0] cur_l;
  logic [PW-1:0] cur;
  assign cur_l = link_r - LW'(1);
  assign cur   = cur_l[PW-1:0];

  always_ff @(posedge clk) begin
    held_rd_r <= held_mem[from_pid_r];
    if (cmd == ipc_pkg::CMD_LOAD) word_r <= PAYLOAD_BITS'(in_data.payload);
    if (cmd == ipc_pkg::CMD_EXEC && req_r.req_type == ipc_pkg::REQ_SEND &&
        req_r.target_kind == ipc_pkg::KIND_PID && pid_ok_c && pid_ok_t &&
        cp != tp && caller_run && !dead_r &&
        !(mode_r[tp] == ipc_pkg::MODE_RECV &&
          (wsrc_r[tp] == 6'(cp) || wsrc_r[tp] == SRC_ANY)))
      held_mem[cp] <= word_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PROCS; i++) begin
        mode_r[i]  <= ipc_pkg::MODE_RUN;
        stgt_r[i]  <= '0;
        wsrc_r[i]  <= '0;
        pend_r[i]  <= 1'b0;
        qhead_r[i] <= '0;
        qnext_r[i] <= '0;
      end
      chain_done_r <= 1'b0;
      dead_r       <= 1'b0;
      walk_act_r   <= 1'b0;
      read_held_r  <= 1'b0;
    end else begin
      unique case (cmd)
        ipc_pkg::CMD_LOAD: begin
          req_r        <= in_data;
          dead_r       <= 1'b0;
          read_held_r  <= 1'b0;
          cnt_r        <= '0;
          wp_r         <= in_data.target_pid[PW-1:0];
          // only sends walk the chain
          chain_done_r <= (in_data.req_type != ipc_pkg::REQ_SEND);
        end
        ipc_pkg::CMD_CHAIN: begin
          if (!chain_done_r) begin
            if (!pid_ok_t || cnt_r == CW'(NUM_PROCS) ||
                mode_r[wp_r] != ipc_pkg::MODE_SEND) begin
              chain_done_r <= 1'b1;
            end else if (stgt_r[wp_r] == cp) begin
              dead_r       <= 1'b1;
              chain_done_r <= 1'b1;
            end else begin
              wp_r  <= stgt_r[wp_r];
              cnt_r <= cnt_r + CW'(1);
            end
          end
        end
        ipc_pkg::CMD_EXEC: begin
          ipc_pkg::out_item_t res_v;
          res_v        = '0;
          res_v.status = ipc_pkg::ST_BAD;
          cnt_r    <= '0;
          unique case (req_r.req_type)
            ipc_pkg::REQ_INT: begin
              if (pid_ok_t) begin
                res_v.status = ipc_pkg::ST_OK;
                if (mode_r[tp] == ipc_pkg::MODE_RECV &&
                    (wsrc_r[tp] == SRC_INT || wsrc_r[tp] == SRC_ANY)) begin
                  mode_r[tp] <= ipc_pkg::MODE_RUN;
                  pend_r[tp] <= 1'b0;
                  res_v.delivered       = 1'b1;
                  res_v.receiver_pid    = req_r.target_pid;
                  res_v.from_interrupt  = 1'b1;
                  res_v.unblocked_valid = 1'b1;
                  res_v.unblocked_pid   = req_r.target_pid;
                end else begin
                  pend_r[tp] <= 1'b1;
                end
              end
            end
            ipc_pkg::REQ_SEND: begin
              if (req_r.target_kind == ipc_pkg::KIND_PID && pid_ok_c && pid_ok_t &&
                  cp != tp && caller_run) begin
                if (dead_r) begin
                  res_v.status = ipc_pkg::ST_DEADLOCK;
                end else if (mode_r[tp] == ipc_pkg::MODE_RECV &&
                             (wsrc_r[tp] == 6'(cp) || wsrc_r[tp] == SRC_ANY)) begin
                  mode_r[tp] <= ipc_pkg::MODE_RUN;
                  res_v.status          = ipc_pkg::ST_OK;
                  res_v.delivered       = 1'b1;
                  res_v.receiver_pid    = req_r.target_pid;
                  res_v.source_pid      = req_r.caller_pid;
                  res_v.msg_word        = 32'(word_r);
                  res_v.unblocked_valid = 1'b1;
                  res_v.unblocked_pid   = req_r.target_pid;
                end else begin
                  mode_r[cp]  <= ipc_pkg::MODE_SEND;
                  stgt_r[cp]  <= tp;
                  qnext_r[cp] <= '0;
                  res_v.status = ipc_pkg::ST_BLOCKED;
                  if (qhead_r[tp] == '0) begin
                    qhead_r[tp] <= LW'(cp) + LW'(1);
                  end else begin
                    walk_act_r    <= 1'b1;
                    walk_unlink_r <= 1'b0;
                    link_r        <= qhead_r[tp];
                    wsub_r        <= cp;
                  end
                end
              end
            end
            ipc_pkg::REQ_RECV: begin
              if (pid_ok_c && req_r.target_kind != 2'd3 && caller_run &&
                  !(req_r.target_kind == ipc_pkg::KIND_PID && (!pid_ok_t || tp == cp))) begin
                if (req_r.target_kind != ipc_pkg::KIND_PID && pend_r[cp]) begin
                  pend_r[cp] <= 1'b0;
                  res_v.status         = ipc_pkg::ST_OK;
                  res_v.delivered      = 1'b1;
                  res_v.receiver_pid   = req_r.caller_pid;
                  res_v.from_interrupt = 1'b1;
                end else if ((req_r.target_kind == ipc_pkg::KIND_ANY &&
                              qhead_r[cp] != '0) ||
                             (req_r.target_kind == ipc_pkg::KIND_PID &&
                              mode_r[tp] == ipc_pkg::MODE_SEND && stgt_r[tp] == cp)) begin
                  logic [LW-1:0] hl;
                  logic [PW-1:0] f;
                  hl = qhead_r[cp] - LW'(1);
                  f  = (req_r.target_kind == ipc_pkg::KIND_ANY) ? hl[PW-1:0] : tp;
                  mode_r[f] <= ipc_pkg::MODE_RUN;
                  from_pid_r  <= f;
                  read_held_r <= 1'b1;
                  res_v.status          = ipc_pkg::ST_OK;
                  res_v.delivered       = 1'b1;
                  res_v.receiver_pid    = req_r.caller_pid;
                  res_v.source_pid      = 4'(f);
                  res_v.unblocked_valid = 1'b1;
                  res_v.unblocked_pid   = 4'(f);
                  walk_act_r    <= 1'b1;
                  walk_unlink_r <= 1'b1;
                  link_r        <= qhead_r[cp];
                  prev_r        <= '0;
                  wsub_r        <= f;
                  owner_r       <= cp;
                end else begin
                  mode_r[cp] <= ipc_pkg::MODE_RECV;
                  wsrc_r[cp] <= (req_r.target_kind == ipc_pkg::KIND_PID) ? 6'(tp) :
                                (req_r.target_kind == ipc_pkg::KIND_ANY) ? SRC_ANY : SRC_INT;
                  res_v.status = ipc_pkg::ST_BLOCKED;
                end
              end
            end
            default: ;
          endcase
          res_r <= res_v;
        end
        ipc_pkg::CMD_WALK: begin
          if (walk_act_r) begin
            cnt_r <= cnt_r + CW'(1);
            if (cnt_r == CW'(NUM_PROCS) || link_r == '0) begin
              walk_act_r <= 1'b0;
            end else if (!walk_unlink_r) begin
              if (qnext_r[cur] == '0) begin
                qnext_r[cur] <= LW'(wsub_r) + LW'(1);
                walk_act_r   <= 1'b0;
              end else begin
                link_r <= qnext_r[cur];
              end
            end else if (cur == wsub_r) begin
              if (prev_r == '0) qhead_r[owner_r] <= qnext_r[cur];
              else begin
                logic [LW-1:0] pl;
                pl = prev_r - LW'(1);
                qnext_r[pl[PW-1:0]] <= qnext_r[cur];
              end
              qnext_r[cur] <= '0;
              walk_act_r   <= 1'b0;
            end else begin
              prev_r <= link_r;
              link_r <= qnext_r[cur];
            end
          end
        end
        ipc_pkg::CMD_DONE: read_held_r <= 1'b0;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hdl/ipc_rendezvous_engine.sv =====
// Sequence from input transfer to result transfer: load, chain walk (sends only),
// execute, queue walk, then the result waits for the output transfer.
// One item at a time: the next input is taken in the cycle after the result transfer.
// The two walks run one after the other over the per-process tables, one entry a cycle.
// Reset (rst_n low, synchronous): all runnable, queues empty, no pending; payload store kept.
// ----------------------------------------------------------------------------
// ipc_rendezvous_engine: blocking rendezvous message passing between processes
// Top level joining the sequencer and the process-table datapath.
// ----------------------------------------------------------------------------
`default_nettype none
module ipc_rendezvous_engine #(
  parameter int NUM_PROCS    = ipc_pkg::NUM_PROCS_DEF,
  parameter int PAYLOAD_BITS = ipc_pkg::PAYLOAD_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire ipc_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output ipc_pkg::out_item_t     out_data
);
  ipc_pkg::cmd_t       cmd;
  ipc_pkg::dp_status_t dp_st;

  // sequencer: one transfer in, walk steps, one transfer out
  ipc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .dp_st, .cmd
  );

  // process tables, payload store and result register
  ipc_dpath #(.NUM_PROCS(NUM_PROCS), .PAYLOAD_BITS(PAYLOAD_BITS)) u_dpath (
    .clk, .rst_n, .cmd, .in_data, .dp_st, .out_data
  );
endmodule
`default_nettype wire

// ===== hdl/ipc_checker.sv =====
// ----------------------------------------------------------------------------
// ipc_checker: port-level checks of the rendezvous engine
// Handshake and result consistency, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module ipc_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire ipc_pkg::out_item_t out_data
);
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall) else $error("second accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("out held");
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("accept while result waits");
  a_block_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ipc_pkg::ST_OK |-> !out_data.delivered)
    else $error("delivery on refused step");
  a_int_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.from_interrupt |-> out_data.msg_word == 32'd0)
    else $error("interrupt carries payload");
endmodule

bind ipc_rendezvous_engine ipc_checker u_chk (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);
`default_nettype wire

// ===== dv/tb_ipc_rendezvous_engine.sv =====
// ----------------------------------------------------------------------------
// tb_ipc_rendezvous_engine: self-checking bench for the rendezvous engine
// Drives send, receive and interrupt requests, predicts each result from a
// process-table model kept in the bench, and compares field by field.
// ----------------------------------------------------------------------------
`default_nettype none

class rendezvous_scoreboard;
  localparam int NP = 16;
  localparam logic [5:0] WAIT_ANY = 6'd62;
  localparam logic [5:0] WAIT_INT = 6'd63;

  logic [1:0]  mode [NP];
  logic [3:0]  dest [NP];
  logic [5:0]  waits_on [NP];
  bit          irq_pend [NP];
  logic [31:0] parked_word [NP];
  logic [4:0]  head [NP];
  logic [4:0]  succ [NP];

  ipc_pkg::out_item_t pending_results[$];
  int errors;

  function void clear();
    for (int p = 0; p < NP; p++) begin
      mode[p] = ipc_pkg::MODE_RUN;
      dest[p] = '0;
      waits_on[p] = '0;
      irq_pend[p] = 0;
      parked_word[p] = '0;
      head[p] = '0;
      succ[p] = '0;
    end
    pending_results.delete();
    errors = 0;
  endfunction

  // true when the blocked-sender chain from dst leads back to src
  function bit loops_back(int src, int dst);
    int p;
    p = dst;
    for (int n = 0; n < NP; n++) begin
      if (mode[p] != ipc_pkg::MODE_SEND) return 0;
      if (dest[p] == src) return 1;
      p = dest[p];
    end
    return 0;
  endfunction

  function void append(int owner, int s);
    int lnk;
    succ[s] = '0;
    lnk = head[owner];
    if (lnk == 0) begin
      head[owner] = 5'(s + 1);
      return;
    end
    for (int n = 0; n < NP; n++) begin
      if (succ[lnk-1] == 0) begin
        succ[lnk-1] = 5'(s + 1);
        return;
      end
      lnk = succ[lnk-1];
    end
  endfunction

  function void detach(int owner, int s);
    int lnk, prv;
    lnk = head[owner];
    prv = 0;
    for (int n = 0; n < NP && lnk != 0; n++) begin
      if (lnk - 1 == s) begin
        if (prv == 0) head[owner] = succ[s];
        else succ[prv-1] = succ[s];
        succ[s] = '0;
        return;
      end
      prv = lnk;
      lnk = succ[lnk-1];
    end
  endfunction

  function void note_request(ipc_pkg::in_item_t it);
    ipc_pkg::out_item_t r;
    int c, t, f;
    r = '0;
    r.status = ipc_pkg::ST_BAD;
    c = it.caller_pid;
    t = it.target_pid;
    case (it.req_type)
      ipc_pkg::REQ_INT: begin
        r.status = ipc_pkg::ST_OK;
        if (mode[t] == ipc_pkg::MODE_RECV &&
            (waits_on[t] == WAIT_INT || waits_on[t] == WAIT_ANY)) begin
          mode[t] = ipc_pkg::MODE_RUN;
          irq_pend[t] = 0;
          r.delivered = 1; r.receiver_pid = t[3:0]; r.from_interrupt = 1;
          r.unblocked_valid = 1; r.unblocked_pid = t[3:0];
        end else begin
          irq_pend[t] = 1;
        end
      end
      ipc_pkg::REQ_SEND: begin
        if (it.target_kind == ipc_pkg::KIND_PID && c != t &&
            mode[c] == ipc_pkg::MODE_RUN) begin
          if (loops_back(c, t)) begin
            r.status = ipc_pkg::ST_DEADLOCK;
          end else if (mode[t] == ipc_pkg::MODE_RECV &&
                       (waits_on[t] == 6'(c) || waits_on[t] == WAIT_ANY)) begin
            mode[t] = ipc_pkg::MODE_RUN;
            r.status = ipc_pkg::ST_OK; r.delivered = 1;
            r.receiver_pid = t[3:0]; r.source_pid = c[3:0]; r.msg_word = it.payload;
            r.unblocked_valid = 1; r.unblocked_pid = t[3:0];
          end else begin
            mode[c] = ipc_pkg::MODE_SEND;
            dest[c] = t[3:0];
            parked_word[c] = it.payload;
            append(t, c);
            r.status = ipc_pkg::ST_BLOCKED;
          end
        end
      end
      ipc_pkg::REQ_RECV: begin
        if (it.target_kind != 2'd3 && mode[c] == ipc_pkg::MODE_RUN &&
            !(it.target_kind == ipc_pkg::KIND_PID && t == c)) begin
          f = -1;
          if (it.target_kind != ipc_pkg::KIND_PID && irq_pend[c]) begin
            irq_pend[c] = 0;
            r.status = ipc_pkg::ST_OK; r.delivered = 1;
            r.receiver_pid = c[3:0]; r.from_interrupt = 1;
          end else begin
            if (it.target_kind == ipc_pkg::KIND_ANY) begin
              if (head[c] != 0) f = head[c] - 1;
            end else if (it.target_kind == ipc_pkg::KIND_PID) begin
              if (mode[t] == ipc_pkg::MODE_SEND && dest[t] == c) f = t;
            end
            if (f >= 0) begin
              detach(c, f);
              mode[f] = ipc_pkg::MODE_RUN;
              r.status = ipc_pkg::ST_OK; r.delivered = 1;
              r.receiver_pid = c[3:0]; r.source_pid = f[3:0];
              r.msg_word = parked_word[f];
              r.unblocked_valid = 1; r.unblocked_pid = f[3:0];
            end else begin
              mode[c] = ipc_pkg::MODE_RECV;
              waits_on[c] = (it.target_kind == ipc_pkg::KIND_PID) ? 6'(t) :
                            (it.target_kind == ipc_pkg::KIND_ANY) ? WAIT_ANY : WAIT_INT;
              r.status = ipc_pkg::ST_BLOCKED;
            end
          end
        end
      end
      default: ;
    endcase
    pending_results.push_back(r);
  endfunction

  function void check_result(ipc_pkg::out_item_t got);
    ipc_pkg::out_item_t exp;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      errors++;
      return;
    end
    exp = pending_results.pop_front();
    if (got.status !== exp.status ||
        got.delivered !== exp.delivered ||
        got.receiver_pid !== exp.receiver_pid ||
        got.source_pid !== exp.source_pid ||
        got.from_interrupt !== exp.from_interrupt ||
        got.msg_word !== exp.msg_word ||
        got.unblocked_valid !== exp.unblocked_valid ||
        got.unblocked_pid !== exp.unblocked_pid) begin
      $display("%0t: result mismatch, expected %h, actual %h", $time, exp, got);
      errors++;
    end
  endfunction
endclass

module tb_ipc_rendezvous_engine;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ipc_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ipc_pkg::out_item_t out_data;

  rendezvous_scoreboard sb = new();

  // idle rates in percent for each side
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit stimulus_done = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  ipc_rendezvous_engine u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // result side: sample at the rising edge, pick the next stall level at the
  // falling edge so it is stable for the whole next cycle
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // one transfer on the input channel, with optional idle cycles first;
  // valid is left high after the transfer and dropped by the next idle or drain
  task automatic issue(ipc_pkg::in_item_t it);
    bit idle;
    idle = ($urandom_range(99) < send_idle_pct);
    if (idle) in_valid <= 1'b0;
    while (idle) begin
      @(negedge clk);
      idle = ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(it);
    @(negedge clk);
  endtask

  task automatic issue_fields(logic [1:0] rq, int c, logic [1:0] k, int t,
                              logic [31:0] w);
    ipc_pkg::in_item_t it;
    it.req_type = rq;
    it.caller_pid = c[3:0];
    it.target_kind = k;
    it.target_pid = t[3:0];
    it.payload = w;
    issue(it);
  endtask

  // random item, mostly well-formed traffic among a small process group so
  // that queues, chains and rendezvous actually happen
  task automatic issue_random();
    ipc_pkg::in_item_t it;
    int roll, span;
    roll = $urandom_range(99);
    span = ($urandom_range(3) == 0) ? 15 : 5;
    it.caller_pid = 4'($urandom_range(span));
    it.target_pid = 4'($urandom_range(span));
    it.payload = $urandom();
    it.target_kind = ipc_pkg::KIND_PID;
    if (roll < 45) begin
      it.req_type = ipc_pkg::REQ_SEND;
    end else if (roll < 85) begin
      it.req_type = ipc_pkg::REQ_RECV;
      if ($urandom_range(2) == 0) it.target_kind = ipc_pkg::KIND_ANY;
      else if ($urandom_range(5) == 0) it.target_kind = ipc_pkg::KIND_INT;
    end else if (roll < 93) begin
      it.req_type = ipc_pkg::REQ_INT;
      it.target_kind = 2'($urandom_range(3));
    end else begin
      // noise: any encoding at all
      it.req_type = 2'($urandom_range(3));
      it.target_kind = 2'($urandom_range(3));
    end
    issue(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    sb.clear();

    // directed: extremes, every request, each refusal case
    issue_fields(2'd3, 0, ipc_pkg::KIND_PID, 1, '1);                 // unknown request
    issue_fields(ipc_pkg::REQ_SEND, 0, 2'd3, 1, 32'h0);              // unknown kind
    issue_fields(ipc_pkg::REQ_SEND, 0, ipc_pkg::KIND_ANY, 1, 32'h0); // send to any
    issue_fields(ipc_pkg::REQ_SEND, 0, ipc_pkg::KIND_INT, 1, 32'h0); // send to irq
    issue_fields(ipc_pkg::REQ_SEND, 3, ipc_pkg::KIND_PID, 3, 32'h0); // to itself
    issue_fields(ipc_pkg::REQ_RECV, 15, ipc_pkg::KIND_PID, 15, '0);  // from itself
    issue_fields(ipc_pkg::REQ_RECV, 15, 2'd3, 0, '0);
    issue_fields(ipc_pkg::REQ_SEND, 0, ipc_pkg::KIND_PID, 15, 32'hFFFF_FFFF); // blocks
    issue_fields(ipc_pkg::REQ_SEND, 1, ipc_pkg::KIND_PID, 15, 32'h0000_0001); // queued
    issue_fields(ipc_pkg::REQ_SEND, 0, ipc_pkg::KIND_PID, 2, 32'h0);  // caller blocked
    issue_fields(ipc_pkg::REQ_SEND, 15, ipc_pkg::KIND_PID, 0, 32'h0); // deadlock
    issue_fields(ipc_pkg::REQ_RECV, 15, ipc_pkg::KIND_PID, 1, '0);    // named, queue tail
    issue_fields(ipc_pkg::REQ_RECV, 15, ipc_pkg::KIND_ANY, 0, '0);    // head
    issue_fields(ipc_pkg::REQ_RECV, 15, ipc_pkg::KIND_INT, 0, '0);    // waits on irq
    issue_fields(ipc_pkg::REQ_INT, 0, 2'd3, 15, 32'hFFFF_FFFF);       // wakes it
    issue_fields(ipc_pkg::REQ_INT, 15, ipc_pkg::KIND_PID, 4, '0);     // sets pending
    issue_fields(ipc_pkg::REQ_RECV, 4, ipc_pkg::KIND_PID, 5, '0);     // named ignores irq
    issue_fields(ipc_pkg::REQ_SEND, 5, ipc_pkg::KIND_PID, 4, 32'hA5A5_5A5A); // rendezvous
    issue_fields(ipc_pkg::REQ_RECV, 4, ipc_pkg::KIND_ANY, 0, '0);     // takes pending
    issue_fields(ipc_pkg::REQ_RECV, 6, ipc_pkg::KIND_ANY, 0, '0);
    issue_fields(ipc_pkg::REQ_SEND, 7, ipc_pkg::KIND_PID, 6, 32'h1234_5678); // to any-waiter
    issue_fields(ipc_pkg::REQ_RECV, 8, ipc_pkg::KIND_ANY, 0, '0);
    issue_fields(ipc_pkg::REQ_INT, 0, 2'd0, 8, '0);                   // irq to any-waiter

    // the sender holds off until the engine has answered everything
    drain();

    send_idle_pct = 20; recv_idle_pct = 78;
    repeat (550) issue_random();
    send_idle_pct = 78; recv_idle_pct = 20;
    repeat (550) issue_random();
    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (550) issue_random();

    drain();
    repeat (60) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog: ~1700 items with their stalls finish well before this
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

`default_nettype wire

// ===== files.f =====
hdl/ipc_pkg.sv
hdl/ipc_ctrl.sv
hdl/ipc_dpath.sv
hdl/ipc_rendezvous_engine.sv
hdl/ipc_checker.sv
dv/tb_ipc_rendezvous_engine.sv
